>>> design/cra_pkg.sv
// Shared widths, opcode and status codes for the contiguous run allocator.
// No dependencies; imported by the top level and its checker.
package cra_pkg;

	localparam int OP_W  = 2;
	localparam int IDX_W = 8;
	localparam int LEN_W = 4;
	localparam int QS_W  = 9;
	localparam int ST_W  = 2;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ST_W-1:0] status_t;

	// request opcodes; the spare code is a no-op that reports done
	localparam op_t OP_ALLOC   = 2'd0;
	localparam op_t OP_RELEASE = 2'd1;
	localparam op_t OP_REINIT  = 2'd2;
	localparam op_t OP_NOP     = 2'd3;

	// result status codes
	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_NOROOM   = 2'd1;
	localparam status_t ST_BADRANGE = 2'd2;

	// queue size after reset
	localparam logic [QS_W-1:0] QS_RESET = 9'd256;

endpackage

>>> design/cra_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the free map of the allocator.
module cra_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/contiguous_run_allocator.sv
// First-fit contiguous run allocator: free map in RAM, free count in flops.
// Depends on cra_pkg and cra_ram.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  request  | start, busy (take: !busy) | opcode, start_index, run_length
//  result   | done (one-cycle strobe)   | status, run_start, free_entries
//  config   | queue_size_we             | queue_size_wdata
//
// Allocate scans one table position a cycle through the single RAM read port.
// Release writes one entry a cycle.
// Reinitialise sweeps the whole table through the write port.
// Bad requests and the spare opcode are answered in the next cycle without going busy.
// After reset the same sweep marks the whole map free, busy high.
// Results cannot be held off; a new request may be taken while done is high.
module contiguous_run_allocator
	import cra_pkg::*;
#(
	parameter int TABLE_DEPTH = 256,
	parameter int MAX_RUN     = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  op_t              opcode,
	input  logic [IDX_W-1:0] start_index,
	input  logic [LEN_W-1:0] run_length,
	input  logic             queue_size_we,
	input  logic [QS_W-1:0]  queue_size_wdata,
	output logic             done,
	output status_t          status,
	output logic [IDX_W-1:0] run_start,
	output logic [QS_W-1:0]  free_entries
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic [QS_W-1:0] DEPTH_CLAMP =
		QS_W'((TABLE_DEPTH > 511) ? 511 : TABLE_DEPTH);
	localparam logic [QS_W-1:0] RESET_FREE =
		QS_W'((TABLE_DEPTH < 256) ? TABLE_DEPTH : 256);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_SWEEP} state_t;

	state_t           state_q;
	logic [QS_W-1:0]  qsize_q;
	logic [QS_W-1:0]  free_total_q;
	logic             done_q;
	status_t          status_q;
	logic [IDX_W-1:0] run_start_q;
	logic             report_q;
	logic [AW-1:0]    sweep_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] run_cnt_q;
	logic [QS_W-1:0]  iss_pos_q;
	logic             chk_vld_s1;
	logic [QS_W-1:0]  chk_pos_s1;
	logic [AW-1:0]    wr_pos_q;
	logic [LEN_W-1:0] wr_left_q;
	logic             wr_val_q;

	logic [QS_W-1:0]  size;
	logic             len_ok;
	logic [QS_W:0]    rel_end;
	logic [QS_W:0]    rel_sum;
	logic [QS_W-1:0]  rel_total;
	logic [QS_W-1:0]  alloc_total;
	logic             issue;
	logic [QS_W-1:0]  found_pos;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_wdata;
	logic             ram_rdata;

	// clamp the queue size to the table
	assign size = (int'(qsize_q) > TABLE_DEPTH) ? DEPTH_CLAMP : qsize_q;

	// request checks and count updates
	assign len_ok      = (run_length != '0) && (int'(run_length) <= MAX_RUN);
	assign rel_end     = {2'b0, start_index} + {6'b0, run_length};
	assign rel_sum     = {1'b0, free_total_q} + {6'b0, run_length};
	assign rel_total   = (rel_sum > {1'b0, size}) ? size : rel_sum[QS_W-1:0];
	assign alloc_total = (free_total_q >= {5'b0, len_q}) ?
		(free_total_q - {5'b0, len_q}) : '0;

	// scan issue and start of the run that ends at the checked position
	assign issue     = iss_pos_q < size;
	assign found_pos = chk_pos_s1 - {5'b0, len_q} + 9'd1;

	// drive the RAM write port from the sequencer
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_pos_q;
		ram_wdata = wr_val_q;
		unique case (state_q)
			S_WRITE: begin
				ram_we = 1'b1;
			end
			S_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	cra_ram #(
		.WIDTH (1),
		.DEPTH (TABLE_DEPTH)
	) u_free_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (AW'(iss_pos_q)),
		.rdata (ram_rdata)
	);

	// sequencer, free count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			qsize_q      <= QS_RESET;
			free_total_q <= RESET_FREE;
			done_q       <= 1'b0;
			status_q     <= ST_DONE;
			run_start_q  <= '0;
			report_q     <= 1'b0;
			sweep_q      <= '0;
			len_q        <= '0;
			run_cnt_q    <= '0;
			iss_pos_q    <= '0;
			chk_vld_s1   <= 1'b0;
			chk_pos_s1   <= '0;
			wr_pos_q     <= '0;
			wr_left_q    <= '0;
			wr_val_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (queue_size_we) begin
				qsize_q <= queue_size_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						len_q       <= run_length;
						run_cnt_q   <= '0;
						iss_pos_q   <= '0;
						chk_vld_s1  <= 1'b0;
						run_start_q <= '0;
						status_q    <= ST_DONE;
						unique case (opcode)
							OP_ALLOC: begin
								if (len_ok && ({5'b0, run_length} <= size)) begin
									state_q <= S_SCAN;
								end else begin
									done_q   <= 1'b1;
									status_q <= ST_NOROOM;
								end
							end
							OP_RELEASE: begin
								if (len_ok && (rel_end <= {1'b0, size})) begin
									wr_pos_q     <= AW'(start_index);
									wr_left_q    <= run_length;
									wr_val_q     <= 1'b1;
									free_total_q <= rel_total;
									state_q      <= S_WRITE;
								end else begin
									done_q   <= 1'b1;
									status_q <= ST_BADRANGE;
								end
							end
							OP_REINIT: begin
								report_q <= 1'b1;
								sweep_q  <= '0;
								state_q  <= S_SWEEP;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					// issue the next position, check the one read last cycle
					chk_vld_s1 <= issue;
					chk_pos_s1 <= iss_pos_q;
					if (issue) begin
						iss_pos_q <= iss_pos_q + 9'd1;
					end
					if (chk_vld_s1) begin
						if (ram_rdata) begin
							if (run_cnt_q + LEN_W'(1) == len_q) begin
								run_start_q  <= IDX_W'(found_pos);
								wr_pos_q     <= AW'(found_pos);
								wr_left_q    <= len_q;
								wr_val_q     <= 1'b0;
								free_total_q <= alloc_total;
								chk_vld_s1   <= 1'b0;
								state_q      <= S_WRITE;
							end else begin
								run_cnt_q <= run_cnt_q + LEN_W'(1);
							end
						end else begin
							run_cnt_q <= '0;
						end
					end else if (!issue) begin
						// every position checked, no run found
						status_q <= ST_NOROOM;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_WRITE: begin
					wr_pos_q  <= wr_pos_q + AW'(1);
					wr_left_q <= wr_left_q - LEN_W'(1);
					if (wr_left_q == LEN_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST_ADDR) begin
						sweep_q  <= '0;
						report_q <= 1'b0;
						state_q  <= S_IDLE;
						if (report_q) begin
							free_total_q <= size;
							done_q       <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign run_start    = run_start_q;
	assign free_entries = free_total_q;

endmodule

>>> design/cra_check.sv
// Port-level checks for the contiguous run allocator, bound to its top level.
// Depends on cra_pkg and contiguous_run_allocator.
module cra_check
	import cra_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input op_t              opcode,
	input logic [LEN_W-1:0] run_length,
	input logic             done,
	input status_t          status,
	input logic [IDX_W-1:0] run_start
);

	// a result is only given while the block is idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// run start is zero on a failed request
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (run_start == '0))
		else $error("run start set on a failed request");

	// reinitialise always sweeps the table
	a_reinit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_REINIT) |=> busy)
		else $error("reinitialise did not go busy");

	// a zero-length allocation is refused at once
	a_zero_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_ALLOC && run_length == '0)
		|=> (done && status == ST_NOROOM))
		else $error("zero-length allocation not refused");

endmodule

bind contiguous_run_allocator cra_check u_cra_check (.*);
